[design/c3cb_pkg.sv]
`timescale 1ns / 1ps
// c3cb_pkg: shared types and constants for the 3x3 convolution block.
// No dependencies; used by every design file.
package c3cb_pkg;

    localparam int PIXEL_BITS    = 8;
    localparam int FILT_W        = 20;
    localparam int TAP_W         = 8;
    localparam int WIN           = 3;
    localparam int NTAPS         = WIN * WIN;
    localparam int CFG_W         = 11;
    localparam int CFG_IDX_W     = 2;
    localparam int CFG_DATA_W    = 64;
    localparam int MAX_HEIGHT    = 1024;
    localparam int HIDX_W        = 10;
    localparam int DEF_MAX_WIDTH = 1024;
    localparam int RESET_WIDTH   = 1024;
    localparam int RESET_HEIGHT  = 1024;

    localparam logic [CFG_DATA_W-1:0] RESET_TAPS_LOW = 64'h1000_10C0_1000_0000;
    localparam logic [TAP_W-1:0]      RESET_TAP_LAST = 8'h00;

    localparam logic MODE_PIXEL = 1'b0;
    localparam logic MODE_DRAIN = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1,
        CFG_TAPS_LOW     = 2'd2,
        CFG_TAP_LAST     = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic                  mode;
        logic [PIXEL_BITS-1:0] pixel;
    } t_in;

    typedef struct packed {
        logic signed [FILT_W-1:0] filtered;
        logic                     frame_end;
    } t_out;

    typedef struct packed {
        logic left;
        logic right;
        logic top;
        logic bottom;
    } t_border;

    typedef logic [NTAPS-1:0][PIXEL_BITS-1:0] t_win_pix;
    typedef logic [NTAPS-1:0][TAP_W-1:0]      t_taps;

endpackage

[design/conv3x3_center_border.sv]
`timescale 1ns / 1ps
// conv3x3_center_border: streaming 3x3 convolution, out-of-frame neighbours take the centre.
// Each result is computed on the transaction that completes its lower-right neighbour
//   (image_width+1 transactions after its own pixel); input stalls while c3cb_mac is not ready.
// Throughput: one transaction per cycle; the line memory does one read and one write per cycle.
// Reset: counters, window, pipeline valids, geometry and taps return to defaults;
//   the line memory is not cleared. Depends on c3cb_pkg, c3cb_ram, c3cb_mac.
module conv3x3_center_border #(
    parameter int MAX_WIDTH = c3cb_pkg::DEF_MAX_WIDTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_ready,
    input  c3cb_pkg::t_in                      i_in_data,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output c3cb_pkg::t_out                     o_out_data,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [c3cb_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [c3cb_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int P     = c3cb_pkg::PIXEL_BITS;
    localparam int CW    = $clog2(MAX_WIDTH);
    localparam int HB    = c3cb_pkg::HIDX_W;
    localparam int RW    = HB + 1;
    localparam int RST_W = (c3cb_pkg::RESET_WIDTH > MAX_WIDTH) ? MAX_WIDTH
                                                               : c3cb_pkg::RESET_WIDTH;

    localparam logic [CW-1:0] WLAST_RST = CW'(RST_W - 1);
    localparam logic [CW-1:0] MAXW_LAST = CW'(MAX_WIDTH - 1);
    localparam logic [HB-1:0] HLAST_RST = HB'(c3cb_pkg::RESET_HEIGHT - 1);
    localparam logic [HB-1:0] MAXH_LAST = HB'(c3cb_pkg::MAX_HEIGHT - 1);
    localparam logic [c3cb_pkg::CFG_W-1:0] CFG_ONE = 'd1;
    localparam logic [c3cb_pkg::CFG_W-1:0] MAX_H   = c3cb_pkg::CFG_W'(c3cb_pkg::MAX_HEIGHT);
    localparam logic [CW-1:0] COL_ONE = 'd1;
    localparam logic [HB-1:0] OY_ONE  = 'd1;
    localparam logic [RW-1:0] ROW_ONE = 'd1;
    localparam logic [RW-1:0] ROW_TWO = 'd2;

    // configuration
    logic [CW-1:0]                     r_wlast;
    logic [HB-1:0]                     r_hlast;
    logic [c3cb_pkg::CFG_DATA_W-1:0]   r_taps_low;
    logic [c3cb_pkg::TAP_W-1:0]        r_tap_last;
    logic [c3cb_pkg::CFG_W-1:0]        cfg_val;
    logic [CW-1:0]                     n_wlast;
    logic [HB-1:0]                     n_hlast;

    // frame position
    logic [CW-1:0] r_col;
    logic [RW-1:0] r_row;
    logic [CW-1:0] r_ox;
    logic [HB-1:0] r_oy;

    logic frame_in, is_pixel, proceed, past_first, emit;
    logic col_wrap, ox_wrap, oy_last, last;
    logic in_fire, rd_en;

    // window stage
    logic                         r_v1;
    logic                         r_emit1;
    logic                         r_last1;
    logic [CW-1:0]                r_addr1;
    logic [P-1:0]                 r_pix1;
    c3cb_pkg::t_border            r_edge1;
    logic                         r_fwd;
    logic [2*P-1:0]               r_fwd_data;
    logic [2:0][2:0][P-1:0]       r_win;
    logic [2:0][2:0][P-1:0]       n_win;
    logic [2*P-1:0]               ram_q;
    logic [2*P-1:0]               rd_word;
    logic [2*P-1:0]               wdata;
    logic [P-1:0]                 a_old, b_old;
    c3cb_pkg::t_win_pix           sel;
    logic                         s1_adv;
    logic                         mac_ready;

    assign o_cfg_ready = 1'b1;
    assign cfg_val     = i_cfg_data[c3cb_pkg::CFG_W-1:0];

    always_comb begin
        if (cfg_val == '0) begin
            n_wlast = '0;
        end else if (32'(cfg_val) > 32'(MAX_WIDTH)) begin
            n_wlast = MAXW_LAST;
        end else begin
            n_wlast = CW'(cfg_val - CFG_ONE);
        end
        if (cfg_val == '0) begin
            n_hlast = '0;
        end else if (cfg_val > MAX_H) begin
            n_hlast = MAXH_LAST;
        end else begin
            n_hlast = HB'(cfg_val - CFG_ONE);
        end
    end

    always_comb begin
        frame_in   = r_row > {1'b0, r_hlast};
        is_pixel   = (i_in_data.mode == c3cb_pkg::MODE_PIXEL) && !frame_in;
        proceed    = is_pixel || frame_in;
        past_first = (r_row >= ROW_TWO) || ((r_row == ROW_ONE) && (r_col != '0));
        emit       = proceed && past_first;
        col_wrap   = r_col == r_wlast;
        ox_wrap    = r_ox == r_wlast;
        oy_last    = r_oy == r_hlast;
        last       = emit && ox_wrap && oy_last;
    end

    assign in_fire    = i_in_valid && o_in_ready;
    assign rd_en      = in_fire && proceed;
    assign s1_adv     = r_v1 && (!r_emit1 || mac_ready);
    assign o_in_ready = !r_v1 || s1_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wlast    <= WLAST_RST;
            r_hlast    <= HLAST_RST;
            r_taps_low <= c3cb_pkg::RESET_TAPS_LOW;
            r_tap_last <= c3cb_pkg::RESET_TAP_LAST;
            r_col      <= '0;
            r_row      <= '0;
            r_ox       <= '0;
            r_oy       <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                c3cb_pkg::CFG_IMAGE_WIDTH: begin
                    r_wlast <= n_wlast;
                    r_col   <= '0;
                    r_row   <= '0;
                    r_ox    <= '0;
                    r_oy    <= '0;
                end
                c3cb_pkg::CFG_IMAGE_HEIGHT: begin
                    r_hlast <= n_hlast;
                    r_col   <= '0;
                    r_row   <= '0;
                    r_ox    <= '0;
                    r_oy    <= '0;
                end
                c3cb_pkg::CFG_TAPS_LOW: begin
                    r_taps_low <= i_cfg_data;
                end
                c3cb_pkg::CFG_TAP_LAST: begin
                    r_tap_last <= i_cfg_data[c3cb_pkg::TAP_W-1:0];
                end
                default: begin
                    r_tap_last <= r_tap_last;
                end
            endcase
        end else if (rd_en) begin
            if (last) begin
                r_col <= '0;
                r_row <= '0;
                r_ox  <= '0;
                r_oy  <= '0;
            end else begin
                if (col_wrap) begin
                    r_col <= '0;
                    r_row <= r_row + ROW_ONE;
                end else begin
                    r_col <= r_col + COL_ONE;
                end
                if (emit) begin
                    if (ox_wrap) begin
                        r_ox <= '0;
                        r_oy <= r_oy + OY_ONE;
                    end else begin
                        r_ox <= r_ox + COL_ONE;
                    end
                end
            end
        end
    end

    c3cb_ram #(
        .WIDTH(2 * P),
        .DEPTH(MAX_WIDTH)
    ) u_line_ram (
        .i_clk   (i_clk),
        .i_we    (s1_adv),
        .i_waddr (r_addr1),
        .i_wdata (wdata),
        .i_re    (rd_en),
        .i_raddr (r_col),
        .o_rdata (ram_q)
    );

    always_comb begin
        logic ok_x;
        logic ok_y;
        rd_word  = r_fwd ? r_fwd_data : ram_q;
        a_old    = rd_word[2*P-1:P];
        b_old    = rd_word[P-1:0];
        wdata    = {b_old, r_pix1};
        n_win[0] = r_win[1];
        n_win[1] = r_win[2];
        n_win[2] = {r_pix1, b_old, a_old};
        for (int dx = 0; dx < c3cb_pkg::WIN; dx++) begin
            for (int dy = 0; dy < c3cb_pkg::WIN; dy++) begin
                ok_x = (dx == 0) ? r_edge1.left : ((dx == 2) ? r_edge1.right : 1'b1);
                ok_y = (dy == 0) ? r_edge1.top  : ((dy == 2) ? r_edge1.bottom : 1'b1);
                sel[c3cb_pkg::WIN*dx+dy] = (ok_x && ok_y) ? n_win[dx][dy] : r_win[2][1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1  <= 1'b0;
            r_fwd <= 1'b0;
            r_win <= '0;
        end else begin
            if (rd_en) begin
                r_v1 <= 1'b1;
            end else if (s1_adv) begin
                r_v1 <= 1'b0;
            end
            if (s1_adv) begin
                r_win <= n_win;
            end
            if (rd_en) begin
                r_fwd <= s1_adv && (r_col == r_addr1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_addr1        <= r_col;
            r_pix1         <= is_pixel ? i_in_data.pixel : '0;
            r_emit1        <= emit;
            r_last1        <= last;
            r_edge1.left   <= r_ox != '0;
            r_edge1.right  <= !ox_wrap;
            r_edge1.top    <= r_oy != '0;
            r_edge1.bottom <= !oy_last;
            r_fwd_data     <= wdata;
        end
    end

    c3cb_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_v1 && r_emit1),
        .o_ready (mac_ready),
        .i_pix   (sel),
        .i_last  (r_last1),
        .i_taps  ({r_tap_last, r_taps_low}),
        .o_valid (o_out_valid),
        .i_ready (i_out_ready),
        .o_data  (o_out_data)
    );

    a_col_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_col <= r_wlast)
        else $error("input column beyond frame width");

    a_ox_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ox <= r_wlast)
        else $error("output column beyond frame width");

    a_oy_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_oy <= r_hlast)
        else $error("output row beyond frame height");

    a_row_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_row <= ({1'b0, r_hlast} + ROW_TWO))
        else $error("input row ran past the drain rows");

endmodule

[design/c3cb_ram.sv]
`timescale 1ns / 1ps
// c3cb_ram: generic single-clock RAM, one write and one read port, registered read.
// Depends on c3cb_pkg for parameter defaults.
module c3cb_ram #(
    parameter int WIDTH = 2 * c3cb_pkg::PIXEL_BITS,
    parameter int DEPTH = c3cb_pkg::DEF_MAX_WIDTH
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/c3cb_mac.sv]
`timescale 1ns / 1ps
// c3cb_mac: four-stage multiply-accumulate pipeline for one 3x3 window.
// Depends on c3cb_pkg for window, tap and result types.
module c3cb_mac (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  c3cb_pkg::t_win_pix i_pix,
    input  logic               i_last,
    input  c3cb_pkg::t_taps    i_taps,
    output logic               o_valid,
    input  logic               i_ready,
    output c3cb_pkg::t_out     o_data
);

    localparam int P  = c3cb_pkg::PIXEL_BITS;
    localparam int TW = c3cb_pkg::TAP_W;
    localparam int N  = c3cb_pkg::NTAPS;
    localparam int G  = c3cb_pkg::WIN;
    localparam int PW = P + TW + 1;
    localparam int SW = PW + 2;
    localparam int FW = PW + 4;

    logic r_v2, r_v3, r_v4, r_v5;
    logic s2_free, s3_free, s4_free, s5_free;

    c3cb_pkg::t_win_pix r_pix2;
    logic               r_last2, r_last3, r_last4;
    logic signed [PW-1:0] r_prod3 [N];
    logic signed [SW-1:0] r_psum4 [G];
    c3cb_pkg::t_out       r_out5;

    logic signed [PW-1:0] n_prod [N];
    logic signed [SW-1:0] n_psum [G];
    logic signed [FW-1:0] n_sum;

    assign s5_free = !r_v5 || i_ready;
    assign s4_free = !r_v4 || s5_free;
    assign s3_free = !r_v3 || s4_free;
    assign s2_free = !r_v2 || s3_free;
    assign o_ready = s2_free;

    always_comb begin
        logic signed [PW-1:0] a_ext;
        logic signed [PW-1:0] b_ext;
        for (int k = 0; k < N; k++) begin
            a_ext = PW'($signed({1'b0, r_pix2[k]}));
            b_ext = PW'($signed(i_taps[k]));
            n_prod[k] = a_ext * b_ext;
        end
    end

    always_comb begin
        for (int g = 0; g < G; g++) begin
            n_psum[g] = SW'(r_prod3[G*g]) + SW'(r_prod3[G*g+1]) + SW'(r_prod3[G*g+2]);
        end
    end

    assign n_sum = FW'(r_psum4[0]) + FW'(r_psum4[1]) + FW'(r_psum4[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (s2_free) r_v2 <= i_valid;
            if (s3_free) r_v3 <= r_v2;
            if (s4_free) r_v4 <= r_v3;
            if (s5_free) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_free && i_valid) begin
            r_pix2  <= i_pix;
            r_last2 <= i_last;
        end
        if (s3_free && r_v2) begin
            r_prod3 <= n_prod;
            r_last3 <= r_last2;
        end
        if (s4_free && r_v3) begin
            r_psum4 <= n_psum;
            r_last4 <= r_last3;
        end
        if (s5_free && r_v4) begin
            r_out5.filtered  <= $signed(n_sum[c3cb_pkg::FILT_W-1:0]);
            r_out5.frame_end <= r_last4;
        end
    end

    assign o_valid = r_v5;
    assign o_data  = r_out5;

endmodule
